FILE: hdl/hccc_pkg.sv
// ----------------------------------------------------------------------------
// hccc_pkg
// Shared types and constants for the HCI command-complete checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hccc_pkg;

  // Item operations
  typedef enum logic [1:0] {
    OpCmd  = 2'd0,
    OpRx   = 2'd1,
    OpLine = 2'd2,
    OpTick = 2'd3
  } op_t;

  // Exchange outcomes
  typedef enum logic [2:0] {
    OutPass     = 3'd0,
    OutLine     = 3'd1,
    OutNotEvent = 3'd2,
    OutBadEvent = 3'd3,
    OutTimeout  = 3'd4
  } outcome_t;

  // Register map (index into the register list)
  localparam logic RegTimeoutMs = 1'b0;

  localparam logic [15:0] TimeoutReset  = 16'd2000;
  localparam logic [15:0] ElapsedMax    = 16'hffff;
  localparam logic [7:0]  LineErrMask   = 8'h1e;
  localparam logic [7:0]  H4EventInd    = 8'h04;
  localparam logic [7:0]  EvtCmdCmpl    = 8'h0e;
  localparam logic [8:0]  MaxEventBytes = 9'd258;
  localparam logic [8:0]  EvtHdrBytes   = 9'd3;
  localparam logic [8:0]  EvtMinBytes   = 9'd7;

  // Event byte positions
  localparam logic [8:0] PosInd    = 9'd0;
  localparam logic [8:0] PosCode   = 9'd1;
  localparam logic [8:0] PosLen    = 9'd2;
  localparam logic [8:0] PosOpLo   = 9'd4;
  localparam logic [8:0] PosOpHi   = 9'd5;
  localparam logic [8:0] PosStatus = 9'd6;

  // Command byte positions
  localparam logic [1:0] CmdPosOpLo = 2'd1;
  localparam logic [1:0] CmdPosOpHi = 2'd2;
  localparam logic [1:0] CmdPosHold = 2'd3;

  // Queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = QPtrW + 1;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       done_res;
    logic [2:0] outcome;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       last;
    logic       line_err;
    logic       is_ind;
    logic       is_cc;
    logic       is_zero;
  } cls_item_t;

endpackage

`default_nettype wire

FILE: hdl/hci_command_complete_checker.sv
// ----------------------------------------------------------------------------
// hci_command_complete_checker
// Host side of one H4 HCI command exchange with command-complete checking.
// ----------------------------------------------------------------------------
//  Channel  | Ports                          | Beat
//  ---------+--------------------------------+------------------------------
//  in       | in_valid/in_ready/in_data      | cmd byte, rx byte, LSR, tick
//  out      | out_valid/out_ready/out_data   | tx byte and exchange result
//  cfg      | cfg_psel..cfg_pready (APB)     | timeout_ms register write
//
//  One beat per clock sustained while out_ready stays high; each beat yields exactly one result beat.
//  The decoder is combinational and writes the queue; the engine updates its
//  state and the result register when it pops the queue head.
//  Reset (rst_n low, sync): exchange idle, timeout_ms = 2000, queue empty.
//  The two-entry queue lets the input keep flowing while a result waits;
//  in_ready drops only once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module hci_command_complete_checker
  import hccc_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  // input beats
  input  wire             in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  // result beats
  output logic            out_valid,
  input  wire             out_ready,
  output out_item_t       out_data,
  // register port
  input  wire             cfg_psel,
  input  wire             cfg_penable,
  input  wire             cfg_pwrite,
  input  wire [2:0]       cfg_paddr,
  input  wire [31:0]      cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);

  logic [15:0] timeout_r, timeout_nxt;
  logic        cfg_wr;
  cls_item_t   cls, head;
  logic        q_full, q_head_valid, q_pop;

  // --- register port: index is paddr[2], word-aligned ---
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    timeout_nxt = timeout_r;
    if (cfg_wr && cfg_paddr[2] == RegTimeoutMs) begin
      timeout_nxt = cfg_pwdata[15:0];
    end
    cfg_prdata = (cfg_paddr[2] == RegTimeoutMs) ? {16'd0, timeout_r} : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TimeoutReset;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  // --- front: decode each beat ---
  hccc_front u_front (
    .item (in_data),
    .cls  (cls)
  );

  assign in_ready = !q_full;

  // --- queue decoupling front and back ---
  hccc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_item  (cls),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (head)
  );

  // --- back: exchange state and result register ---
  hccc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .timeout_ms (timeout_r),
    .q_valid    (q_head_valid),
    .q_item     (head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

FILE: hdl/hccc_front.sv
// ----------------------------------------------------------------------------
// hccc_front
// Decodes an input beat into a classified item for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hccc_front
  import hccc_pkg::*;
(
  input  wire in_item_t  item,
  output cls_item_t      cls
);

  always_comb begin
    cls.op       = op_t'(item.operation);
    cls.data     = item.data;
    cls.last     = item.last;
    cls.line_err = |(item.data & LineErrMask);
    cls.is_ind   = (item.data == H4EventInd);
    cls.is_cc    = (item.data == EvtCmdCmpl);
    cls.is_zero  = (item.data == 8'd0);
  end

endmodule

`default_nettype wire

FILE: hdl/hccc_queue.sv
// ----------------------------------------------------------------------------
// hccc_queue
// Short register FIFO between the front decoder and the back engine.
// ----------------------------------------------------------------------------
`default_nettype none

module hccc_queue
  import hccc_pkg::*;
(
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  wire cls_item_t push_item,
  output logic           full,
  input  wire            pop,
  output logic           head_valid,
  output cls_item_t      head_item
);

  cls_item_t        mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == QCntW'(QDepth));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hccc_back.sv
// ----------------------------------------------------------------------------
// hccc_back
// Exchange engine: command capture, event framing, timeout and result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module hccc_back
  import hccc_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire [15:0]      timeout_ms,
  input  wire             q_valid,
  input  wire cls_item_t  q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  wire             out_ready,
  output out_item_t       out_data
);

  logic [8:0]  rx_cnt_r,  rx_cnt_nxt;
  logic [8:0]  exp_len_r, exp_len_nxt;
  logic [1:0]  cmd_pos_r, cmd_pos_nxt;
  logic [7:0]  op_lo_r,   op_lo_nxt;
  logic [7:0]  op_hi_r,   op_hi_nxt;
  logic        mism_r,    mism_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        fin_r,     fin_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, res;

  logic [1:0]  cmd_pos_base;
  logic [8:0]  cnt_inc;
  logic [15:0] el_inc;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    rx_cnt_nxt   = rx_cnt_r;
    exp_len_nxt  = exp_len_r;
    cmd_pos_nxt  = cmd_pos_r;
    op_lo_nxt    = op_lo_r;
    op_hi_nxt    = op_hi_r;
    mism_nxt     = mism_r;
    elapsed_nxt  = elapsed_r;
    fin_nxt      = fin_r;
    res          = '0;
    cmd_pos_base = cmd_pos_r;
    cnt_inc      = rx_cnt_r + 9'd1;
    el_inc       = (elapsed_r != ElapsedMax) ? elapsed_r + 16'd1 : elapsed_r;

    if (q_item.op == OpCmd) begin
      // first byte of a new exchange wipes the old one
      if (fin_r) begin
        rx_cnt_nxt   = '0;
        exp_len_nxt  = EvtHdrBytes;
        cmd_pos_base = '0;
        op_lo_nxt    = '0;
        op_hi_nxt    = '0;
        mism_nxt     = 1'b0;
        elapsed_nxt  = '0;
        fin_nxt      = 1'b0;
      end
      res.tx_valid = 1'b1;
      res.tx_byte  = q_item.data;
      if (cmd_pos_base == CmdPosOpLo) begin
        op_lo_nxt = q_item.data;
      end else if (cmd_pos_base == CmdPosOpHi) begin
        op_hi_nxt = q_item.data;
      end
      cmd_pos_nxt = (q_item.last || cmd_pos_base == CmdPosHold) ?
                    CmdPosHold : cmd_pos_base + 2'd1;
    end else if (!fin_r) begin
      case (q_item.op)
        OpLine: begin
          if (q_item.line_err) begin
            fin_nxt      = 1'b1;
            res.done_res = 1'b1;
            res.outcome  = OutLine;
          end
        end
        OpTick: begin
          elapsed_nxt = el_inc;
          if (el_inc >= timeout_ms) begin
            fin_nxt      = 1'b1;
            res.done_res = 1'b1;
            res.outcome  = OutTimeout;
          end
        end
        OpRx: begin
          if (rx_cnt_r >= MaxEventBytes) begin
            fin_nxt      = 1'b1;
            res.done_res = 1'b1;
            res.outcome  = OutBadEvent;
          end else if (rx_cnt_r == PosInd && !q_item.is_ind) begin
            rx_cnt_nxt   = 9'd1;
            fin_nxt      = 1'b1;
            res.done_res = 1'b1;
            res.outcome  = OutNotEvent;
          end else begin
            case (rx_cnt_r)
              PosCode:   if (!q_item.is_cc) mism_nxt = 1'b1;
              PosLen:    exp_len_nxt = EvtHdrBytes + {1'b0, q_item.data};
              PosOpLo:   if (q_item.data != op_lo_r) mism_nxt = 1'b1;
              PosOpHi:   if (q_item.data != op_hi_r) mism_nxt = 1'b1;
              PosStatus: if (!q_item.is_zero) mism_nxt = 1'b1;
              default: ;
            endcase
            rx_cnt_nxt = cnt_inc;
            if (cnt_inc == exp_len_nxt) begin
              fin_nxt      = 1'b1;
              res.done_res = 1'b1;
              res.outcome  = (cnt_inc < EvtMinBytes || mism_nxt) ? OutBadEvent : OutPass;
            end
          end
        end
        default: ;
      endcase
    end

    out_valid_nxt = q_pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_cnt_r    <= '0;
      exp_len_r   <= EvtHdrBytes;
      cmd_pos_r   <= '0;
      op_lo_r     <= '0;
      op_hi_r     <= '0;
      mism_r      <= 1'b0;
      elapsed_r   <= '0;
      fin_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        rx_cnt_r  <= rx_cnt_nxt;
        exp_len_r <= exp_len_nxt;
        cmd_pos_r <= cmd_pos_nxt;
        op_lo_r   <= op_lo_nxt;
        op_hi_r   <= op_hi_nxt;
        mism_r    <= mism_nxt;
        elapsed_r <= elapsed_nxt;
        fin_r     <= fin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire
